// ===== rtl/minv_pkg.sv =====
// Package for the 64-bit modular inverse block.
// Holds the default operand width and the status type of the shift-subtract unit.
// No dependencies.
package minv_pkg;

	// Default operand width; the payload fields are always 64 bits wide.
	localparam int DATA_WIDTH_DEF = 64;
	localparam int FIELD_WIDTH = 64;

	// Status returned by the shift-subtract unit to the sequencer.
	typedef struct packed {
		logic le;    // shifted divisor is not above the running remainder
		logic fits;  // divisor may be shifted one more place without overflow
	} minv_cmp_t;

endpackage

// ===== rtl/minv_if.sv =====
// Channel interfaces of the modular inverse block: request and response.
// Depends on minv_pkg for the field width.
interface minv_req_if;
	logic                          valid;
	logic                          ready;
	logic [minv_pkg::FIELD_WIDTH-1:0] value;
	logic [minv_pkg::FIELD_WIDTH-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

interface minv_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [minv_pkg::FIELD_WIDTH-1:0] inverse;
	logic                          exists;

	modport source (output valid, output inverse, output exists, input ready);
	modport sink (input valid, input inverse, input exists, output ready);
endinterface

// ===== rtl/modular_inverse_64_core.sv =====
// Modular inverse core: extended Euclid with a shared shift-subtract unit.
// Request channel req carries value and modulus; response channel rsp carries
// inverse and exists. Both use valid/ready; a transaction completes when both
// are high at a rising edge of clk. Only the low DATA_WIDTH bits of the
// operands are used.
// The block works on one transaction at a time: req.ready is high only while
// idle. Each Euclid step loads the step, aligns the divisor by shifting it up
// one place per quotient bit, then subtracts one bit at a time on the way back
// down, all through the single shift-subtract unit. A zero operand goes
// straight from idle to the response state.
// The result is held in the response register with rsp.valid high until the
// receiver takes it; a stalled receiver simply holds the block in that state.
// Reset (arst_n low) returns the sequencer to idle and drops rsp.valid.
// Depends on minv_pkg, minv_if and minv_shsub.
module modular_inverse_64_core #(
	parameter int DATA_WIDTH = minv_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	minv_req_if.sink    req,
	minv_rsp_if.source  rsp
);
	import minv_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ALIGN,
		ST_SUB,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t         state_q;
	logic [W-1:0]   r0_q, r1_q, s0_q, s1_q, rem_q, srem_q, m_q, inv_q;
	logic [KW-1:0]  k_q;
	logic           exists_q;

	minv_cmp_t      cmp;
	logic [W-1:0]   rem_diff, srem_diff, rem_new, srem_new;
	logic [W-1:0]   a_in, m_in;

	assign a_in = req.value[W-1:0];
	assign m_in = req.modulus[W-1:0];

	// Shared shift-subtract unit.
	minv_shsub #(.W(W), .KW(KW)) u_shsub (
		.r1        (r1_q),
		.s1        (s1_q),
		.rem       (rem_q),
		.srem      (srem_q),
		.k         (k_q),
		.up        (state_q == ST_ALIGN),
		.cmp       (cmp),
		.rem_diff  (rem_diff),
		.srem_diff (srem_diff)
	);

	// Remainder and coefficient after the current subtract cycle.
	assign rem_new  = cmp.le ? rem_diff : rem_q;
	assign srem_new = cmp.le ? srem_diff : srem_q;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = (state_q == ST_OUT);
	assign rsp.inverse = FIELD_WIDTH'(inv_q);
	assign rsp.exists  = exists_q;

	// Sequencer with its registered datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			exists_q <= 1'b0;
			r0_q     <= '0;
			r1_q     <= '0;
			s0_q     <= '0;
			s1_q     <= '0;
			rem_q    <= '0;
			srem_q   <= '0;
			m_q      <= '0;
			inv_q    <= '0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						r0_q     <= a_in;
						r1_q     <= m_in;
						m_q      <= m_in;
						s0_q     <= W'(1);
						s1_q     <= '0;
						inv_q    <= '0;
						exists_q <= 1'b0;
						if (a_in == '0 || m_in == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rem_q  <= r0_q;
					srem_q <= s0_q;
					k_q    <= '0;
					state_q <= (r1_q == '0) ? ST_FIN : ST_ALIGN;
				end
				ST_ALIGN: begin
					if (cmp.fits && cmp.le) begin
						k_q <= k_q + KW'(1);
					end else begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					rem_q  <= rem_new;
					srem_q <= srem_new;
					if (k_q == '0) begin
						r0_q    <= r1_q;
						r1_q    <= rem_new;
						s0_q    <= s1_q;
						s1_q    <= srem_new;
						state_q <= ST_LOAD;
					end else begin
						k_q <= k_q - KW'(1);
					end
				end
				ST_FIN: begin
					// A negative coefficient is brought into range by adding the modulus.
					if (r0_q == W'(1)) begin
						exists_q <= 1'b1;
						inv_q    <= s0_q[W-1] ? (m_q + s0_q) : s0_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/minv_shsub.sv =====
// Shared shift-subtract unit of the modular inverse block.
// Shifts divisor and coefficient, compares against the remainder and subtracts.
// Depends on minv_pkg.
module minv_shsub #(
	parameter int W  = 64,
	parameter int KW = 6
) (
	input  logic [W-1:0]  r1,
	input  logic [W-1:0]  s1,
	input  logic [W-1:0]  rem,
	input  logic [W-1:0]  srem,
	input  logic [KW-1:0] k,
	input  logic          up,
	output minv_pkg::minv_cmp_t cmp,
	output logic [W-1:0]  rem_diff,
	output logic [W-1:0]  srem_diff
);
	import minv_pkg::*;

	logic [W-1:0] d;
	logic [W-1:0] ds;
	logic [KW-1:0] top_idx;

	// Divisor and coefficient shifted by k, or by k+1 while aligning.
	always_comb begin
		d  = r1 << k;
		ds = s1 << k;
		if (up) begin
			d  = d << 1;
			ds = ds << 1;
		end
	end

	// The next shift keeps r1 << (k+1) in range when bit W-1-k of r1 is clear.
	assign top_idx   = KW'(W - 1) - k;
	assign cmp.fits  = (k != KW'(W - 1)) && !r1[top_idx];
	assign cmp.le    = (d <= rem);
	assign rem_diff  = rem - d;
	assign srem_diff = srem - ds;

endmodule

// ===== tb/tb_modular_inverse_64_core.sv =====
// Testbench for modular_inverse_64_core: a directed table, then random operand pairs,
// each checked against the known table value or else the extended-Euclid predictor.
// Depends on minv_pkg, minv_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_modular_inverse_64_core;
	import minv_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic [63:0] modulus;
		bit          known;
		logic [63:0] inverse;
		logic        exists;
	} stim_row_t;

	typedef struct {
		logic [63:0] inverse;
		logic        exists;
	} inv_result_t;

	localparam int N_RANDOM = 1750;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	minv_req_if req_ch ();
	minv_rsp_if rsp_ch ();

	modular_inverse_64_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	inv_result_t pending_q[$];
	int     errors;
	bit     stim_done;
	bit     hold_done;
	longint cycles;

	// Extended Euclid with the coefficient kept modulo 2^64.
	function automatic inv_result_t predict_inverse(logic [63:0] a, logic [63:0] m);
		inv_result_t res;
		logic [63:0] r0, r1, r2, s0, s1, s2, q;
		res.inverse = '0;
		res.exists = 1'b0;
		r0 = a;
		r1 = m;
		s0 = 64'd1;
		s1 = 64'd0;
		if (a == 0 || m == 0)
			return res;
		while (r1 != 0) begin
			q = r0 / r1;
			r2 = r0 - q * r1;
			s2 = s0 - q * s1;
			r0 = r1;
			r1 = r2;
			s0 = s1;
			s1 = s2;
		end
		if (r0 != 1)
			return res;
		if (s0[63])
			res.inverse = m - (64'd0 - s0);
		else
			res.inverse = s0 % m;
		res.exists = 1'b1;
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Operands with a random bit length, so small moduli dominate now and then.
	function automatic logic [63:0] rand_sized();
		int n;
		logic [63:0] v;
		n = $urandom_range(1, 64);
		v = rand64();
		return (n == 64) ? v : (v & ((64'd1 << n) - 1));
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset, asserted at start and then released.
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Directed table, then random transactions with random gaps.
	initial begin
		stim_row_t   table_rows[$];
		stim_row_t   row;
		inv_result_t pred;
		inv_result_t exp_item;
		int          i;
		bit          quiet;
		req_ch.valid = 1'b0;
		req_ch.value = '0;
		req_ch.modulus = '0;
		stim_done = 1'b0;
		table_rows = '{
			'{64'd0, 64'd0, 1, 64'd0, 1'b0},
			'{64'd0, 64'd1, 1, 64'd0, 1'b0},
			'{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
			'{64'd5, 64'd0, 1, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1, 64'd0, 1'b0},
			'{64'd7, 64'd1, 1, 64'd0, 1'b1},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1, 64'd0, 1'b1},
			'{64'd4, 64'd6, 1, 64'd0, 1'b0},
			'{64'd6, 64'd4, 1, 64'd0, 1'b0},
			'{64'd3, 64'd7, 1, 64'd5, 1'b1},
			'{64'd1, 64'd2, 1, 64'd1, 1'b1},
			'{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd1, 1'b1},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 0, 64'd0, 1'b0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0, 64'd0, 1'b0},
			'{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'd0, 1'b0},
			'{64'hA24B_AED4_963E_E407, 64'h9E37_79B9_7F4A_7C15, 0, 64'd0, 1'b0},
			'{64'd12345, 64'hFFFF_FFFF_FFFF_FFC5, 0, 64'd0, 1'b0},
			'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 0, 64'd0, 1'b0}
		};
		@(posedge clk iff arst_n);
		for (i = 0; i < table_rows.size() + N_RANDOM; i++) begin
			if (i < table_rows.size()) begin
				row = table_rows[i];
			end else begin
				case ($urandom_range(0, 9))
					0: begin row.value = rand64(); row.modulus = rand64(); end
					1: begin row.value = rand_sized(); row.modulus = 64'd0; end
					2: begin row.value = rand_sized() * 2; row.modulus = rand_sized() * 2; end
					default: begin row.value = rand_sized(); row.modulus = rand_sized(); end
				endcase
				row.known = 0;
			end
			pred = predict_inverse(row.value, row.modulus);
			if (row.known && (pred.inverse !== row.inverse || pred.exists !== row.exists))
				$display("%0t table row %0d: expected %h/%b, predictor %h/%b", $time, i,
					row.inverse, row.exists, pred.inverse, pred.exists);
			// Gaps before the item, except in a quiet stretch in the middle.
			quiet = (i >= 600 && i < 900);
			while (!quiet && $urandom_range(0, 99) < 20) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
			req_ch.valid <= 1'b1;
			req_ch.value <= row.value;
			req_ch.modulus <= row.modulus;
			@(posedge clk iff req_ch.ready);
			if (row.known) begin
				exp_item.inverse = row.inverse;
				exp_item.exists = row.exists;
			end else begin
				exp_item = pred;
			end
			pending_q.insert(pending_q.size(), exp_item);
		end
		req_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: one long hold-off early on, then random stalls with a quiet stretch.
	initial begin
		int accepted;
		int k;
		rsp_ch.ready = 1'b0;
		hold_done = 1'b0;
		accepted = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (accepted == 30 && !hold_done) begin
				for (k = 0; k < 3000; k++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			rsp_ch.ready <= (accepted >= 600 && accepted < 900) || ($urandom_range(0, 99) >= 20);
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				accepted++;
				rsp_ch.ready <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		inv_result_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t unexpected transaction: inverse %h exists %b", $time,
					rsp_ch.inverse, rsp_ch.exists);
				errors++;
			end else begin
				exp_res = pending_q.pop_front();
				if (rsp_ch.inverse !== exp_res.inverse) begin
					$display("%0t inverse mismatch: expected %h, actual %h", $time,
						exp_res.inverse, rsp_ch.inverse);
					errors++;
				end
				if (rsp_ch.exists !== exp_res.exists) begin
					$display("%0t exists mismatch: expected %b, actual %b", $time,
						exp_res.exists, rsp_ch.exists);
					errors++;
				end
			end
		end
	end

	// Cycle counter and end of run.
	initial begin
		errors = 0;
		cycles = 0;
		fork
			forever begin
				@(posedge clk);
				cycles++;
			end
		join_none
		wait (stim_done && pending_q.size() == 0 || cycles >= CYCLE_LIMIT);
		if (cycles < CYCLE_LIMIT)
			repeat (500) @(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout, %0d transactions outstanding", $time, pending_q.size());
			$display("tb_modular_inverse_64_core: FAIL");
		end else if (errors == 0 && pending_q.size() == 0) begin
			$display("tb_modular_inverse_64_core: PASS");
		end else begin
			$display("tb_modular_inverse_64_core: FAIL");
		end
		$finish;
	end

endmodule

// ===== modular_inverse_64_core.f =====
rtl/minv_pkg.sv
rtl/minv_if.sv
rtl/minv_shsub.sv
rtl/modular_inverse_64_core.sv
tb/tb_modular_inverse_64_core.sv
